// ===== hdl/dibu_pkg.sv =====
package dibu_pkg;

  // Fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_W      = 11;   // image_width / image_height registers
  localparam int PAL_SIZE_W = 9;
  localparam int POS_W      = 13;   // pixel byte position within a row stride
  localparam int XY_W       = 11;   // internal column / row
  localparam int COORD_W    = 10;   // column / row on the output
  localparam int CNT_W      = 4;    // pixels per input byte, 1..8
  localparam int IDX_W      = 8;    // palette index
  localparam int ADDR_W     = 8;    // memory address carried between modules
  localparam int COLOR_W    = 24;

  // Output queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_CNT_W = 2;

  // p / 3 as (p * K) >> S, exact for p below 2**(S-1)
  localparam int RECIP3_K = 10923;
  localparam int RECIP3_S = 15;

  // Register reset values
  localparam logic [2:0]            DEPTH_RST    = 3'd4;
  localparam logic [DIM_W-1:0]      WIDTH_RST    = 11'd32;
  localparam logic [DIM_W-1:0]      HEIGHT_RST   = 11'd32;
  localparam logic [PAL_SIZE_W-1:0] PAL_SIZE_RST = 9'd0;
  localparam logic                  MASK_RST     = 1'b1;

  typedef enum logic [1:0] {
    MODE_PAL  = 2'd0,
    MODE_MASK = 2'd1,
    MODE_PIX  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_24 = 3'd3,
    DEPTH_32 = 3'd4
  } depth_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH    = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_PAL_SIZE = 3'd3,
    CFG_MASK     = 3'd4
  } cfg_reg_e;

  // Effective configuration seen by the pixel path
  typedef struct packed {
    logic [DIM_W-1:0]      width;
    logic [PAL_SIZE_W-1:0] pal_n;
    logic                  mask_present;
  } dibu_cfg_t;

  // Memory writes issued at input transfer
  typedef struct packed {
    logic               pal_we;
    logic [ADDR_W-1:0]  pal_addr;
    logic [COLOR_W-1:0] pal_data;
    logic               mask_we;
    logic [ADDR_W-1:0]  mask_addr;
    logic [7:0]         mask_data;
  } dibu_wr_t;

  // One pixel-producing input byte
  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   cnt;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    row;
    logic               last_row;
    logic [2:0]         depth;
    logic [7:0]         data;
    logic [COLOR_W-1:0] color;
  } dibu_job_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_of_item;
    logic               last_of_image;
  } dibu_pix_t;

  // Largest usable width for a given MAX_WIDTH (register is 11 bits)
  function automatic int dibu_max_w(int max_width);
    return (max_width > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : max_width;
  endfunction

  // Bytes of one mask row stride at the largest usable width
  function automatic int dibu_mask_bytes(int max_width);
    return ((dibu_max_w(max_width) + 31) / 32) * 4;
  endfunction

endpackage

// ===== hdl/dibu_if.sv =====
interface dibu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic [7:0]  data_byte;

  modport source (output valid, mode, palette_index, palette_color, data_byte, input ready);
  modport sink (input valid, mode, palette_index, palette_color, data_byte, output ready);
endinterface

interface dibu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [9:0] column;
  logic [9:0] row;
  logic       last_of_item;
  logic       last_of_image;

  modport source (output valid, red, green, blue, alpha, column, row, last_of_item,
                  last_of_image, input ready);
  modport sink (input valid, red, green, blue, alpha, column, row, last_of_item,
                last_of_image, output ready);
endinterface

// ===== hdl/dib_icon_pixel_unpacker.sv =====
// Channel   Dir  Handshake              Payload
// item_i    in   valid/ready transfer   mode, palette_index, palette_color, data_byte
// pixel_o   out  valid/ready transfer   red, green, blue, alpha, column, row,
//                                        last_of_item, last_of_image
// cfg       in   cfg_we_i write         cfg_idx_i selects register, cfg_data_i value
//
// Rate: one pixel leaves per cycle while the output queue has room. A byte that makes
//   n pixels holds the input until its last pixel issues (up to 8 at 1 bpp, up to 2 at
//   4 bpp, 1 otherwise); items making no pixel do not hold it. The rate is set by the
//   single palette read port, one lookup per pixel.
// Path: job register, read stage and output queue lie between input transfer and pixel_o.
// Reset: control state clears at once; palette, mask line and pixel data are not cleared.
// Stalls: a 3-entry output queue absorbs pixels in flight; issue waits on queue room.
//
// Structure:
//   dibu_front  - config registers, row/mask byte positions, 24/32-bit gathering;
//                 turns each pixel-producing byte into a job of 1..8 pixels and
//                 palette/mask items into memory writes.
//   dibu_issue  - job register stepped one pixel per cycle while the queue has room,
//                 palette and mask-line memories (sync read), color/alpha resolve.
//   dibu_ofifo  - output queue driving the pixel channel.
// A new item is taken only when idle or as the job issues its last pixel, so memory
// writes never race the reads of an earlier byte (reads see the old data on that edge).
module dib_icon_pixel_unpacker import dibu_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dibu_in_if.sink               item_i,
  dibu_out_if.source            pixel_o
);

  dibu_cfg_t             cfg;
  dibu_wr_t              wr;
  dibu_job_t             job;
  logic                  job_ready;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  push;
  dibu_pix_t             pix;

  dibu_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .job_ready_i (job_ready),
    .cfg_o       (cfg),
    .wr_o        (wr),
    .job_o       (job)
  );

  dibu_issue #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .wr_i        (wr),
    .job_i       (job),
    .job_ready_o (job_ready),
    .fifo_cnt_i  (fifo_cnt),
    .push_o      (push),
    .pix_o       (pix)
  );

  dibu_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pix_i   (pix),
    .cnt_o   (fifo_cnt),
    .pixel_o (pixel_o)
  );

endmodule

// ===== hdl/dibu_front.sv =====
module dibu_front import dibu_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dibu_in_if.sink               item_i,
  input  logic                  job_ready_i,
  output dibu_cfg_t             cfg_o,
  output dibu_wr_t              wr_o,
  output dibu_job_t             job_o
);

  localparam int MAXW_I     = dibu_max_w(MAX_WIDTH);
  localparam int MAXH_I     = dibu_max_w(MAX_HEIGHT);
  localparam int MASK_BYTES = dibu_mask_bytes(MAX_WIDTH);
  localparam int MA         = $clog2(MASK_BYTES);
  localparam logic [DIM_W-1:0] MAXW_C = DIM_W'(MAXW_I);
  localparam logic [DIM_W-1:0] MAXH_C = DIM_W'(MAXH_I);
  localparam logic [PAL_SIZE_W-1:0] PAL_DEPTH_C = PAL_SIZE_W'(PALETTE_DEPTH);

  // Configuration registers
  logic [2:0]            depth_q;
  logic [DIM_W-1:0]      width_q, height_q;
  logic [PAL_SIZE_W-1:0] pal_size_q;
  logic                  mask_q;

  // Row tracking state
  logic [MA-1:0]      mbp_q, mbp_d;
  logic [POS_W-1:0]   pbp_q, pbp_d;
  logic [XY_W-1:0]    row_q, row_d;
  logic [COLOR_W-1:0] gath_q, gath_d;
  logic [1:0]         gcnt_q, gcnt_d;

  logic [DIM_W-1:0]         w_eff, h_eff;
  logic                     accept;
  logic [15:0]              wbits;
  logic [POS_W-1:0]         stride, data_bytes;
  logic [8:0]               mstride;
  logic                     in_data, row_end, depth_ok, last_row;
  logic [15:0]              rem;
  logic [CNT_W-1:0]         npix;
  logic [XY_W-1:0]          xbase;
  logic [POS_W+RECIP3_S-1:0] div3_prod;
  logic [COLOR_W-1:0]       color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= DEPTH_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      pal_size_q <= PAL_SIZE_RST;
      mask_q     <= MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEPTH:    depth_q    <= cfg_data_i[2:0];
        CFG_WIDTH:    width_q    <= cfg_data_i;
        CFG_HEIGHT:   height_q   <= cfg_data_i;
        CFG_PAL_SIZE: pal_size_q <= cfg_data_i[PAL_SIZE_W-1:0];
        CFG_MASK:     mask_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbp_q  <= '0;
      pbp_q  <= '0;
      row_q  <= '0;
      gath_q <= '0;
      gcnt_q <= '0;
    end else begin
      mbp_q  <= mbp_d;
      pbp_q  <= pbp_d;
      row_q  <= row_d;
      gath_q <= gath_d;
      gcnt_q <= gcnt_d;
    end
  end

  assign item_i.ready = job_ready_i;
  assign accept       = item_i.valid && job_ready_i;

  always_comb begin
    w_eff = (width_q == '0) ? DIM_W'(1) : width_q;
    if (w_eff > MAXW_C) w_eff = MAXW_C;
    h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
    if (h_eff > MAXH_C) h_eff = MAXH_C;
  end

  assign cfg_o.width        = w_eff;
  assign cfg_o.pal_n        = (pal_size_q > PAL_DEPTH_C) ? PAL_DEPTH_C : pal_size_q;
  assign cfg_o.mask_present = mask_q;

  // Row geometry
  always_comb begin
    unique case (depth_q)
      DEPTH_1:  wbits = 16'(w_eff);
      DEPTH_4:  wbits = 16'(w_eff) << 2;
      DEPTH_8:  wbits = 16'(w_eff) << 3;
      DEPTH_24: wbits = (16'(w_eff) << 4) + (16'(w_eff) << 3);
      DEPTH_32: wbits = 16'(w_eff) << 5;
      default:  wbits = '0;
    endcase
  end

  assign depth_ok   = (depth_q <= DEPTH_32);
  assign stride     = POS_W'(((17'(wbits) + 17'd31) >> 5) << 2);
  assign data_bytes = POS_W'((17'(wbits) + 17'd7) >> 3);
  assign mstride    = 9'(((12'(w_eff) + 12'd31) >> 5) << 2);
  assign in_data    = (pbp_q < data_bytes);
  assign row_end    = ((14'(pbp_q) + 14'd1) >= 14'(stride));
  assign last_row   = ((12'(row_q) + 12'd1) >= 12'(h_eff));
  assign div3_prod  = (POS_W+RECIP3_S)'(pbp_q) * (POS_W+RECIP3_S)'(RECIP3_K);

  // Pixels completed by this byte and the column of the first one
  always_comb begin
    rem   = '0;
    npix  = '0;
    xbase = '0;
    color = '0;
    unique case (depth_q)
      DEPTH_1: begin
        rem   = 16'(w_eff) - (16'(pbp_q) << 3);
        npix  = (rem >= 16'd8) ? CNT_W'(8) : CNT_W'(rem);
        xbase = XY_W'(16'(pbp_q) << 3);
      end
      DEPTH_4: begin
        rem   = 16'(w_eff) - (16'(pbp_q) << 1);
        npix  = (rem >= 16'd2) ? CNT_W'(2) : CNT_W'(1);
        xbase = XY_W'(16'(pbp_q) << 1);
      end
      DEPTH_8: begin
        npix  = CNT_W'(1);
        xbase = XY_W'(pbp_q);
      end
      DEPTH_24: begin
        npix  = (gcnt_q >= 2'd2) ? CNT_W'(1) : CNT_W'(0);
        xbase = XY_W'(div3_prod >> RECIP3_S);
        color = {item_i.data_byte, gath_q[15:0]};
      end
      DEPTH_32: begin
        npix  = (gcnt_q == 2'd3) ? CNT_W'(1) : CNT_W'(0);
        xbase = XY_W'(pbp_q >> 2);
        color = gath_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    mbp_d  = mbp_q;
    pbp_d  = pbp_q;
    row_d  = row_q;
    gath_d = gath_q;
    gcnt_d = gcnt_q;

    wr_o.pal_we    = accept && (item_i.mode == MODE_PAL) &&
                     (9'(item_i.palette_index) < 9'(PALETTE_DEPTH));
    wr_o.pal_addr  = item_i.palette_index;
    wr_o.pal_data  = item_i.palette_color;
    wr_o.mask_we   = accept && (item_i.mode == MODE_MASK);
    wr_o.mask_addr = ADDR_W'(mbp_q);
    wr_o.mask_data = item_i.data_byte;

    job_o.valid    = accept && (item_i.mode == MODE_PIX) && depth_ok && in_data &&
                     (npix != '0);
    job_o.cnt      = npix;
    job_o.x        = xbase;
    job_o.row      = row_q;
    job_o.last_row = last_row;
    job_o.depth    = depth_q;
    job_o.data     = item_i.data_byte;
    job_o.color    = color;

    if (accept && (item_i.mode == MODE_MASK)) begin
      mbp_d = ((9'(mbp_q) + 9'd1) >= mstride) ? '0 : MA'(9'(mbp_q) + 9'd1);
    end

    if (accept && (item_i.mode == MODE_PIX) && depth_ok) begin
      // Gather 24/32-bit pixels, low byte first
      if (in_data && ((depth_q == DEPTH_24) || (depth_q == DEPTH_32))) begin
        if (npix != '0) begin
          gath_d = '0;
          gcnt_d = '0;
        end else begin
          case (gcnt_q)
            2'd0:    gath_d = gath_q | {16'd0, item_i.data_byte};
            2'd1:    gath_d = gath_q | {8'd0, item_i.data_byte, 8'd0};
            2'd2:    gath_d = gath_q | {item_i.data_byte, 16'd0};
            default: gath_d = gath_q;
          endcase
          gcnt_d = gcnt_q + 2'd1;
        end
      end
      if (row_end) begin
        pbp_d  = '0;
        gath_d = '0;
        gcnt_d = '0;
        row_d  = last_row ? '0 : row_q + XY_W'(1);
      end else begin
        pbp_d = pbp_q + POS_W'(1);
      end
    end
  end

endmodule

// ===== hdl/dibu_issue.sv =====
module dibu_issue import dibu_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dibu_cfg_t             cfg_i,
  input  dibu_wr_t              wr_i,
  input  dibu_job_t             job_i,
  output logic                  job_ready_o,
  input  logic [FIFO_CNT_W-1:0] fifo_cnt_i,
  output logic                  push_o,
  output dibu_pix_t             pix_o
);

  localparam int MASK_BYTES = dibu_mask_bytes(MAX_WIDTH);
  localparam int MA         = $clog2(MASK_BYTES);
  localparam int PA         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  typedef struct packed {
    logic               black;
    logic               use_pal;
    logic               alpha_dir;
    logic [COLOR_W-1:0] color;
    logic [7:0]         alpha;
    logic [2:0]         bitpos;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_item;
    logic               last_image;
  } rd_t;

  logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [7:0]         mask_mem [MASK_BYTES];
  logic [COLOR_W-1:0] pal_rdata_q;
  logic [7:0]         mask_rdata_q;

  logic       j_valid_q;
  dibu_job_t  job_q;
  logic [2:0] k_q;
  logic       r_valid_q;
  rd_t        r_q, r_d;

  logic             credit_ok, issue, last_pix, use_pal;
  logic [XY_W-1:0]  x;
  logic [IDX_W-1:0] idx;
  logic             mask_bit;

  // Issue only while the output queue plus the read stage has room
  assign credit_ok   = ((3'(fifo_cnt_i) + 3'(r_valid_q)) < 3'(FIFO_DEPTH));
  assign issue       = j_valid_q && credit_ok;
  assign last_pix    = ((CNT_W'(k_q) + CNT_W'(1)) == job_q.cnt);
  assign job_ready_o = !j_valid_q || (issue && last_pix);
  assign x           = job_q.x + XY_W'(k_q);

  always_comb begin
    unique case (job_q.depth)
      DEPTH_1: idx = {7'd0, job_q.data[3'd7 - k_q]};
      DEPTH_4: idx = (k_q == 3'd0) ? {4'd0, job_q.data[7:4]} : {4'd0, job_q.data[3:0]};
      default: idx = job_q.data;
    endcase
    use_pal = (job_q.depth == DEPTH_1) || (job_q.depth == DEPTH_4) ||
              (job_q.depth == DEPTH_8);

    r_d.black      = use_pal && (9'(idx) >= cfg_i.pal_n);
    r_d.use_pal    = use_pal;
    r_d.alpha_dir  = (job_q.depth == DEPTH_32);
    r_d.color      = job_q.color;
    r_d.alpha      = job_q.data;
    r_d.bitpos     = x[2:0];
    r_d.column     = COORD_W'(x);
    r_d.row        = COORD_W'(job_q.row);
    r_d.last_item  = last_pix;
    r_d.last_image = ((12'(x) + 12'd1) == 12'(cfg_i.width)) && job_q.last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q <= 1'b0;
      k_q       <= '0;
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= issue;
      if (job_ready_o) begin
        j_valid_q <= job_i.valid;
        k_q       <= '0;
      end else if (issue) begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_i.valid) job_q <= job_i;
    if (issue) r_q <= r_d;
  end

  // Palette and mask line: one write (from the input side), one read per pixel
  always_ff @(posedge clk_i) begin
    if (wr_i.pal_we) pal_mem[wr_i.pal_addr[PA-1:0]] <= wr_i.pal_data;
    if (issue) pal_rdata_q <= pal_mem[idx[PA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.mask_we) mask_mem[wr_i.mask_addr[MA-1:0]] <= wr_i.mask_data;
    if (issue) mask_rdata_q <= mask_mem[x[MA+2:3]];
  end

  // Resolve color and alpha once read data is back
  logic [COLOR_W-1:0] color_res;
  logic [7:0]         alpha_res;

  assign mask_bit = mask_rdata_q[3'd7 - r_q.bitpos];

  always_comb begin
    if (r_q.black) color_res = '0;
    else if (r_q.use_pal) color_res = pal_rdata_q;
    else color_res = r_q.color;

    if (r_q.alpha_dir) alpha_res = r_q.alpha;
    else if (!cfg_i.mask_present) alpha_res = 8'd255;
    else alpha_res = mask_bit ? 8'd0 : 8'd255;
  end

  assign push_o              = r_valid_q;
  assign pix_o.red           = color_res[23:16];
  assign pix_o.green         = color_res[15:8];
  assign pix_o.blue          = color_res[7:0];
  assign pix_o.alpha         = alpha_res;
  assign pix_o.column        = r_q.column;
  assign pix_o.row           = r_q.row;
  assign pix_o.last_of_item  = r_q.last_item;
  assign pix_o.last_of_image = r_q.last_image;

endmodule

// ===== hdl/dibu_ofifo.sv =====
module dibu_ofifo import dibu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dibu_pix_t             pix_i,
  output logic [FIFO_CNT_W-1:0] cnt_o,
  dibu_out_if.source            pixel_o
);

  dibu_pix_t             ent_q [FIFO_DEPTH];
  logic [FIFO_CNT_W-1:0] wr_q, rd_q, cnt_q;
  logic                  pop;
  dibu_pix_t             head;

  assign pop   = pixel_o.valid && pixel_o.ready;
  assign cnt_o = cnt_q;
  assign head  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == FIFO_CNT_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_CNT_W'(1);
      if (pop) rd_q <= (rd_q == FIFO_CNT_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_CNT_W'(1);
      if (push_i && !pop) cnt_q <= cnt_q + FIFO_CNT_W'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= pix_i;
  end

  assign pixel_o.valid         = (cnt_q != '0);
  assign pixel_o.red           = head.red;
  assign pixel_o.green         = head.green;
  assign pixel_o.blue          = head.blue;
  assign pixel_o.alpha         = head.alpha;
  assign pixel_o.column        = head.column;
  assign pixel_o.row           = head.row;
  assign pixel_o.last_of_item  = head.last_of_item;
  assign pixel_o.last_of_image = head.last_of_image;

endmodule
